// ===== sv/bclru_pkg.sv =====
// Shared constants and the cell command type for the sector cache tag controller.
package bclru_pkg;

    localparam int unsigned SECTOR_W  = 32;
    localparam int unsigned SIB_W     = 3;                  // eight sectors per block
    localparam int unsigned BLOCK_W   = SECTOR_W - SIB_W;
    localparam int unsigned LIMIT_W   = 7;
    localparam int unsigned ENTRY_O_W = 6;
    localparam logic [LIMIT_W-1:0] CLEAN_LIMIT_RESET = 7'd32;

    // Broadcast to every cell in the update cycle.
    typedef struct packed {
        logic apply;       // update cycle
        logic is_write;    // request is a sector write
        logic hit_clean;   // hit on a clean entry: matching cell is the target
        logic insert;      // miss with a free entry: first free cell is the target
        logic evict_old;   // existing LRU clean entry leaves
        logic victim_new;  // the just inserted entry is the one evicted
    } t_cell_cmd;

endpackage

// ===== sv/block_cache_lru_dirty_pin.sv =====
// A request is captured while idle; its response is registered in the update cycle, and
// no new request is taken before that. The row of entry cells is looked up and updated in
// the same cycle, so only request capture and the update cycle are spent.
// A response still waiting in the output register holds the update cycle, and with it
// the next acceptance, until that response is taken.
// Reset (synchronous, active low) empties all entries, zeroes the clean count and
// sets clean_limit to 32; no clearing pass is needed.
module block_cache_lru_dirty_pin #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bclru_pkg::LIMIT_W-1:0]        i_cfg_wdata,
    input  logic                                 i_req_valid,
    output logic                                 o_req_ready,
    input  logic                                 i_func,
    input  logic [bclru_pkg::SECTOR_W-1:0]       i_sector_number,
    output logic                                 o_rsp_valid,
    input  logic                                 i_rsp_ready,
    output logic                                 o_hit,
    output logic [bclru_pkg::ENTRY_O_W-1:0]      o_entry_index,
    output logic [bclru_pkg::SIB_W-1:0]          o_sector_in_block,
    output logic                                 o_evicted,
    output logic [bclru_pkg::BLOCK_W-1:0]        o_evicted_block,
    output logic                                 o_status
);

    localparam int unsigned RANK_W = $clog2(ENTRIES);
    localparam int unsigned IDX_W  = $clog2(ENTRIES);
    localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
    localparam int unsigned CMP_W  = (CNT_W > bclru_pkg::LIMIT_W) ? CNT_W : bclru_pkg::LIMIT_W;
    localparam int unsigned XW     = (IDX_W > bclru_pkg::ENTRY_O_W) ? IDX_W
                                                                    : bclru_pkg::ENTRY_O_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORK = 1'b1;

    logic                            r_state;
    logic [bclru_pkg::LIMIT_W-1:0]   r_limit;
    logic [CNT_W-1:0]                r_count;

    logic                            r_func;
    logic [bclru_pkg::BLOCK_W-1:0]   r_block;
    logic [bclru_pkg::SIB_W-1:0]     r_sib;

    logic                            r_rsp_valid;
    logic                            r_hit;
    logic [bclru_pkg::ENTRY_O_W-1:0] r_idx;
    logic [bclru_pkg::SIB_W-1:0]     r_sib_out;
    logic                            r_ev;
    logic [bclru_pkg::BLOCK_W-1:0]   r_ev_block;
    logic                            r_status;

    logic [ENTRIES-1:0]              w_match;
    logic [ENTRIES-1:0]              w_clean;
    logic [ENTRIES-1:0]              w_victim;
    logic [ENTRIES-1:0]              w_slot;
    logic [ENTRIES:0]                w_chain;
    logic [RANK_W-1:0]               w_rank  [ENTRIES];
    logic [bclru_pkg::BLOCK_W-1:0]   w_cblk  [ENTRIES];

    logic                            w_hit_any;
    logic                            w_found_clean;
    logic [RANK_W-1:0]               w_found_rank;
    logic [IDX_W-1:0]                w_hit_idx;
    logic [IDX_W-1:0]                w_slot_idx;
    logic [bclru_pkg::BLOCK_W-1:0]   w_vic_block;
    logic                            w_any_free;
    logic                            w_insert;
    logic [CNT_W-1:0]                w_count_ins;
    logic                            w_evict;
    logic                            w_go;
    logic [RANK_W-1:0]               w_rank_ref;
    logic [RANK_W-1:0]               w_rank_new;
    logic [IDX_W-1:0]                w_idx;
    logic [XW-1:0]                   w_idx_ext;
    bclru_pkg::t_cell_cmd            w_cmd;

    assign o_req_ready = (r_state == ST_IDLE);
    assign w_go        = (r_state == ST_WORK) && (!r_rsp_valid || i_rsp_ready);

    assign w_chain[0] = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        bclru_cell #(
            .RANK_W (RANK_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_block     (r_block),
            .i_rank_ref  (w_rank_ref),
            .i_rank_new  (w_rank_new),
            .i_free_seen (w_chain[g]),
            .o_free_seen (w_chain[g+1]),
            .o_match     (w_match[g]),
            .o_clean     (w_clean[g]),
            .o_victim    (w_victim[g]),
            .o_slot      (w_slot[g]),
            .o_rank      (w_rank[g]),
            .o_block     (w_cblk[g])
        );
    end

    // reductions over the row; at most one cell raises each of match, slot, victim
    always_comb begin
        w_hit_any     = 1'b0;
        w_found_clean = 1'b0;
        w_found_rank  = '0;
        w_hit_idx     = '0;
        w_slot_idx    = '0;
        w_vic_block   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_hit_any     = w_hit_any | w_match[i];
            w_found_clean = w_found_clean | (w_match[i] & w_clean[i]);
            w_found_rank  = w_found_rank | (w_match[i] ? w_rank[i] : '0);
            w_hit_idx     = w_hit_idx | (w_match[i] ? IDX_W'(i) : '0);
            w_slot_idx    = w_slot_idx | (w_slot[i] ? IDX_W'(i) : '0);
            w_vic_block   = w_vic_block | (w_victim[i] ? w_cblk[i] : '0);
        end
    end

    assign w_any_free  = w_chain[ENTRIES];
    assign w_insert    = !w_hit_any && w_any_free;
    assign w_count_ins = r_count + CNT_W'(!r_func);
    assign w_evict     = w_insert && (w_count_ins != '0)
                         && (CMP_W'(w_count_ins) >= CMP_W'(r_limit));

    always_comb begin
        w_cmd.apply      = w_go;
        w_cmd.is_write   = r_func;
        w_cmd.hit_clean  = w_hit_any && w_found_clean;
        w_cmd.insert     = w_insert;
        w_cmd.evict_old  = w_evict && (r_count != '0);
        w_cmd.victim_new = w_evict && (r_count == '0);
    end

    assign w_rank_ref = w_hit_any ? w_found_rank : '0;

    always_comb begin
        if (r_func) begin
            w_rank_new = '0;
        end else if (w_hit_any || w_cmd.evict_old) begin
            w_rank_new = RANK_W'(r_count - CNT_W'(1));
        end else begin
            w_rank_new = RANK_W'(r_count);
        end
    end

    assign w_idx     = w_hit_any ? w_hit_idx : (w_insert ? w_slot_idx : '0);
    assign w_idx_ext = XW'(w_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_limit     <= bclru_pkg::CLEAN_LIMIT_RESET;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (w_go) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req_valid) begin
                        r_state <= ST_WORK;
                    end
                end
                ST_WORK: begin
                    if (w_go) begin
                        r_state <= ST_IDLE;
                        if (w_cmd.hit_clean && r_func) begin
                            r_count <= r_count - CNT_W'(1);
                        end else if (w_insert) begin
                            r_count <= w_count_ins - CNT_W'(w_evict);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_func  <= i_func;
            r_block <= i_sector_number[bclru_pkg::SECTOR_W-1:bclru_pkg::SIB_W];
            r_sib   <= i_sector_number[bclru_pkg::SIB_W-1:0];
        end
        if (w_go) begin
            r_hit      <= w_hit_any;
            r_idx      <= w_idx_ext[bclru_pkg::ENTRY_O_W-1:0];
            r_sib_out  <= r_sib;
            r_ev       <= w_evict;
            r_ev_block <= w_cmd.victim_new ? r_block
                        : (w_cmd.evict_old ? w_vic_block : '0);
            r_status   <= !w_hit_any && !w_any_free;
        end
    end

    assign o_rsp_valid       = r_rsp_valid;
    assign o_hit             = r_hit;
    assign o_entry_index     = r_idx;
    assign o_sector_in_block = r_sib_out;
    assign o_evicted         = r_ev;
    assign o_evicted_block   = r_ev_block;
    assign o_status          = r_status;

`ifndef SYNTHESIS
    a_unique_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WORK) |-> $onehot0(w_match))
        else $error("more than one entry holds the requested block");

    a_one_lru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_cmd.evict_old) |-> $onehot(w_victim))
        else $error("eviction without a single least recently used clean entry");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_clean) == 32'(r_count))
        else $error("clean count disagrees with clean entries");

    a_rsp_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> (r_rsp_valid && r_state == ST_IDLE))
        else $error("update cycle did not produce a response");
`endif

endmodule

// ===== sv/bclru_cell.sv =====
// One cache entry: tag, valid, dirty and recency rank, with the first-free chain link.
module bclru_cell #(
    parameter int unsigned RANK_W = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bclru_pkg::t_cell_cmd           i_cmd,
    input  logic [bclru_pkg::BLOCK_W-1:0]  i_block,
    input  logic [RANK_W-1:0]              i_rank_ref,
    input  logic [RANK_W-1:0]              i_rank_new,
    input  logic                           i_free_seen,
    output logic                           o_free_seen,
    output logic                           o_match,
    output logic                           o_clean,
    output logic                           o_victim,
    output logic                           o_slot,
    output logic [RANK_W-1:0]              o_rank,
    output logic [bclru_pkg::BLOCK_W-1:0]  o_block
);

    logic                          r_valid, n_valid;
    logic                          r_dirty, n_dirty;
    logic [RANK_W-1:0]             r_rank,  n_rank;
    logic [bclru_pkg::BLOCK_W-1:0] r_block, n_block;
    logic                          w_clean;
    logic                          w_target;

    assign w_clean     = r_valid && !r_dirty;
    assign o_free_seen = i_free_seen || !r_valid;
    assign o_slot      = !r_valid && !i_free_seen;
    assign o_match     = r_valid && (r_block == i_block);
    assign o_clean     = w_clean;
    assign o_victim    = w_clean && (r_rank == '0);
    assign o_rank      = r_rank;
    assign o_block     = r_block;

    assign w_target = (i_cmd.hit_clean && o_match) || (i_cmd.insert && o_slot);

    always_comb begin
        n_valid = r_valid;
        n_dirty = r_dirty;
        n_rank  = r_rank;
        n_block = r_block;
        if (i_cmd.apply) begin
            if (w_target) begin
                n_valid = i_cmd.insert ? !i_cmd.victim_new : 1'b1;
                n_dirty = i_cmd.is_write;
                n_rank  = i_rank_new;
                if (i_cmd.insert) begin
                    n_block = i_block;
                end
            end else if (i_cmd.evict_old && o_victim) begin
                n_valid = 1'b0;
                n_dirty = 1'b0;
            end else if ((i_cmd.hit_clean || i_cmd.evict_old) && w_clean
                         && (r_rank > i_rank_ref)) begin
                // close the gap left in the recency order
                n_rank = r_rank - RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_block <= n_block;
    end

endmodule

// ===== test/bclru_access_checker.sv =====
// Access checker for the sector cache tag controller: tracks cache state, checks responses.
`timescale 1ns / 100ps

module bclru_access_checker #(
    parameter int ENTRIES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bclru_pkg::LIMIT_W-1:0]     i_cfg_wdata,
    input  logic                              i_req_valid,
    input  logic                              i_req_ready,
    input  logic                              i_func,
    input  logic [bclru_pkg::SECTOR_W-1:0]    i_sector_number,
    input  logic                              i_rsp_valid,
    input  logic                              i_rsp_ready,
    input  logic                              i_hit,
    input  logic [bclru_pkg::ENTRY_O_W-1:0]   i_entry_index,
    input  logic [bclru_pkg::SIB_W-1:0]       i_sector_in_block,
    input  logic                              i_evicted,
    input  logic [bclru_pkg::BLOCK_W-1:0]     i_evicted_block,
    input  logic                              i_status,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int REPORT_LIMIT = 40;

    typedef struct packed {
        logic                              hit;
        logic [bclru_pkg::ENTRY_O_W-1:0]   entry;
        logic [bclru_pkg::SIB_W-1:0]       sib;
        logic                              evicted;
        logic [bclru_pkg::BLOCK_W-1:0]     ev_block;
        logic                              status;
    } t_access_rsp;

    bit                             line_valid [ENTRIES];
    bit                             line_dirty [ENTRIES];
    logic [bclru_pkg::BLOCK_W-1:0]  line_tag   [ENTRIES];
    int unsigned                    line_rank  [ENTRIES];   // 0 = least recently used
    int unsigned                    clean_lines;
    logic [bclru_pkg::LIMIT_W-1:0]  clean_limit;
    t_access_rsp                    rsp_fifo[$];
    int                             fail_count = 0;

    assign o_fail_count = fail_count;

    // Pull a clean line out of the recency order; ranks above it close the gap.
    function automatic void drop_from_order(int e);
        int unsigned r;
        int i;
        r = line_rank[e];
        for (i = 0; i < ENTRIES; i++) begin
            if (line_valid[i] && !line_dirty[i] && i != e && line_rank[i] > r)
                line_rank[i]--;
        end
        if (clean_lines > 0)
            clean_lines--;
        line_rank[e] = 0;
    endfunction

    function automatic t_access_rsp predict_access(logic wr,
                                                   logic [bclru_pkg::SECTOR_W-1:0] sector);
        t_access_rsp r;
        logic [bclru_pkg::BLOCK_W-1:0] blk;
        int hit_line;
        int free_line;
        int victim;
        int i;
        r = '0;
        blk = sector[bclru_pkg::SECTOR_W-1:bclru_pkg::SIB_W];
        r.sib = sector[bclru_pkg::SIB_W-1:0];
        hit_line = -1;
        free_line = -1;
        victim = -1;
        for (i = 0; i < ENTRIES; i++) begin
            if (hit_line < 0 && line_valid[i] && line_tag[i] == blk)
                hit_line = i;
        end
        if (hit_line >= 0) begin
            r.hit = 1'b1;
            r.entry = bclru_pkg::ENTRY_O_W'(hit_line);
            // dirty lines are pinned: nothing moves
            if (!line_dirty[hit_line]) begin
                drop_from_order(hit_line);
                if (wr) begin
                    line_dirty[hit_line] = 1'b1;
                end else begin
                    line_rank[hit_line] = clean_lines;
                    clean_lines++;
                end
            end
        end else begin
            for (i = 0; i < ENTRIES; i++) begin
                if (free_line < 0 && !line_valid[i])
                    free_line = i;
            end
            if (free_line < 0) begin
                r.status = 1'b1;
            end else begin
                r.entry = bclru_pkg::ENTRY_O_W'(free_line);
                line_valid[free_line] = 1'b1;
                line_tag[free_line] = blk;
                line_rank[free_line] = 0;
                if (wr) begin
                    line_dirty[free_line] = 1'b1;
                end else begin
                    line_dirty[free_line] = 1'b0;
                    line_rank[free_line] = clean_lines;
                    clean_lines++;
                end
                // a limit of zero behaves as one; the new line itself may be the victim
                if (clean_lines > 0 && clean_lines >= clean_limit) begin
                    for (i = 0; i < ENTRIES; i++) begin
                        if (victim < 0 && line_valid[i] && !line_dirty[i] && line_rank[i] == 0)
                            victim = i;
                    end
                    if (victim >= 0) begin
                        r.evicted = 1'b1;
                        r.ev_block = line_tag[victim];
                        drop_from_order(victim);
                        line_valid[victim] = 1'b0;
                        line_dirty[victim] = 1'b0;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_access_rsp want;
        int i;
        if (!i_rst_n) begin
            for (i = 0; i < ENTRIES; i++) begin
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
                line_rank[i] = 0;
            end
            clean_lines = 0;
            clean_limit = bclru_pkg::CLEAN_LIMIT_RESET;
            rsp_fifo.delete();
        end else begin
            if (i_cfg_we)
                clean_limit = i_cfg_wdata;
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_fifo.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"%0t: response with no request outstanding, expected none,",
                                  " got hit %0h entry %0h status %0h"},
                                 $time, i_hit, i_entry_index, i_status);
                end else begin
                    want = rsp_fifo.pop_front();
                    check_field("hit", 32'(want.hit), 32'(i_hit));
                    check_field("entry_index", 32'(want.entry), 32'(i_entry_index));
                    check_field("sector_in_block", 32'(want.sib), 32'(i_sector_in_block));
                    check_field("evicted", 32'(want.evicted), 32'(i_evicted));
                    check_field("evicted_block", 32'(want.ev_block), 32'(i_evicted_block));
                    check_field("status", 32'(want.status), 32'(i_status));
                end
            end
            if (i_req_valid && i_req_ready)
                rsp_fifo.push_back(predict_access(i_func, i_sector_number));
        end
        o_pending <= rsp_fifo.size();
    end

endmodule

// ===== test/tb_block_cache_lru_dirty_pin.sv =====
// Testbench top for the sector cache tag controller: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_block_cache_lru_dirty_pin;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_stall_mode;

    localparam logic FUNC_READ      = 1'b0;
    localparam logic FUNC_WRITE     = 1'b1;
    localparam int   READ_POOL      = 32;
    localparam int   WRITE_POOL     = 10;
    localparam int   PHASE_ITEMS    = 85;
    localparam int   HOLD_CYCLES    = 80;
    localparam int   STALL_HEAVY    = 76;
    localparam int   STALL_BOTH     = 36;
    localparam int   WATCHDOG_LIMIT = 3000;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [bclru_pkg::LIMIT_W-1:0]       i_cfg_wdata = '0;
    logic                                i_req_valid = 1'b0;
    logic                                o_req_ready;
    logic                                i_func = 1'b0;
    logic [bclru_pkg::SECTOR_W-1:0]      i_sector_number = '0;
    logic                                o_rsp_valid;
    logic                                i_rsp_ready = 1'b0;
    logic                                o_hit;
    logic [bclru_pkg::ENTRY_O_W-1:0]     o_entry_index;
    logic [bclru_pkg::SIB_W-1:0]         o_sector_in_block;
    logic                                o_evicted;
    logic [bclru_pkg::BLOCK_W-1:0]       o_evicted_block;
    logic                                o_status;

    t_stall_mode                         stall_mode = IDLE_NONE;
    int                                  hold_seq = 0;
    int                                  hold_seen = 0;
    int                                  hold_left = 0;
    int                                  quiet_cycles = 0;
    int                                  fail_count;
    int                                  pending;
    logic [bclru_pkg::BLOCK_W-1:0]       read_pool [READ_POOL];
    logic [bclru_pkg::BLOCK_W-1:0]       write_pool [WRITE_POOL];

    always #2 i_clk = ~i_clk;

    block_cache_lru_dirty_pin i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_req_valid       (i_req_valid),
        .o_req_ready       (o_req_ready),
        .i_func            (i_func),
        .i_sector_number   (i_sector_number),
        .o_rsp_valid       (o_rsp_valid),
        .i_rsp_ready       (i_rsp_ready),
        .o_hit             (o_hit),
        .o_entry_index     (o_entry_index),
        .o_sector_in_block (o_sector_in_block),
        .o_evicted         (o_evicted),
        .o_evicted_block   (o_evicted_block),
        .o_status          (o_status)
    );

    bclru_access_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_req_valid       (i_req_valid),
        .i_req_ready       (o_req_ready),
        .i_func            (i_func),
        .i_sector_number   (i_sector_number),
        .i_rsp_valid       (o_rsp_valid),
        .i_rsp_ready       (i_rsp_ready),
        .i_hit             (o_hit),
        .i_entry_index     (o_entry_index),
        .i_sector_in_block (o_sector_in_block),
        .i_evicted         (o_evicted),
        .i_evicted_block   (o_evicted_block),
        .i_status          (o_status),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    function automatic int stall_pct(t_stall_mode m, bit recv_side);
        case (m)
            IDLE_SEND: return recv_side ? 0 : STALL_HEAVY;
            IDLE_RECV: return recv_side ? STALL_HEAVY : 0;
            IDLE_BOTH: return STALL_BOTH;
            default:   return 0;
        endcase
    endfunction

    // Response side: random stalls, plus one long hold-off each time hold_seq moves.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES - 1;
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= ($urandom_range(99) >= stall_pct(stall_mode, 1'b1));
        end
    end

    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_access(logic fn, logic [bclru_pkg::SECTOR_W-1:0] sector);
        int pct;
        pct = stall_pct(stall_mode, 1'b0);
        if (pct != 0) begin
            while ($urandom_range(99) < pct) begin
                i_req_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_req_valid <= 1'b1;
        i_func <= fn;
        i_sector_number <= sector;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
    endtask

    // Stop offering requests and wait until every response is back.
    task automatic pause_until_idle();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic begin_phase(t_stall_mode m, logic [bclru_pkg::LIMIT_W-1:0] limit);
        pause_until_idle();
        stall_mode <= m;
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly pool blocks so hits, promotions and evictions recur; writes stay in a
    // small pool since dirty lines never leave the cache.
    task automatic send_mixed(bit noisy);
        int pick;
        logic [bclru_pkg::BLOCK_W-1:0] blk;
        logic fn;
        pick = $urandom_range(99);
        fn = FUNC_READ;
        if (pick < 55) begin
            blk = read_pool[$urandom_range(READ_POOL-1)];
        end else if (pick < 65) begin
            blk = write_pool[$urandom_range(WRITE_POOL-1)];
        end else if (pick < 85) begin
            blk = write_pool[$urandom_range(WRITE_POOL-1)];
            fn = FUNC_WRITE;
        end else if (noisy) begin
            blk = bclru_pkg::BLOCK_W'($urandom);
        end else begin
            blk = read_pool[$urandom_range(READ_POOL-1)];
        end
        send_access(fn, {blk, bclru_pkg::SIB_W'($urandom_range(7))});
        if ($urandom_range(99) == 0)
            pause_until_idle();
    endtask

    task automatic run_phase(t_stall_mode m, logic [bclru_pkg::LIMIT_W-1:0] limit,
                             bit noisy, bit long_hold);
        begin_phase(m, limit);
        if (long_hold)
            hold_seq <= hold_seq + 1;
        repeat (PHASE_ITEMS) send_mixed(noisy);
    endtask

    initial begin
        int i;
        for (i = 0; i < READ_POOL; i++)
            read_pool[i] = {23'($urandom), 1'b0, 5'(i)};
        for (i = 0; i < WRITE_POOL; i++)
            write_pool[i] = {23'($urandom), 1'b1, 5'(i)};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limit: misses, clean hit promotion, write hit on clean, dirty hits
        send_access(FUNC_READ,  32'h0000_0000);
        send_access(FUNC_READ,  32'h0000_0007);
        send_access(FUNC_READ,  32'hFFFF_FFFF);
        send_access(FUNC_WRITE, 32'hFFFF_FFFA);
        send_access(FUNC_WRITE, 32'hFFFF_FFFF);
        send_access(FUNC_READ,  32'hFFFF_FFF8);
        send_access(FUNC_WRITE, 32'h0000_0010);
        send_access(FUNC_READ,  32'h0000_0008);
        send_access(FUNC_READ,  32'h0000_0000);
        // tight limit: read miss evicts LRU, write miss evicts too
        begin_phase(IDLE_NONE, 7'd2);
        send_access(FUNC_READ,  32'h0000_0018);
        send_access(FUNC_WRITE, 32'h0000_0020);
        // zero limit: last clean line pinned, then a read miss evicts itself
        begin_phase(IDLE_NONE, 7'd0);
        send_access(FUNC_WRITE, 32'h0000_0018);
        send_access(FUNC_READ,  32'h0000_0028);
        // limit above the entry count: no eviction
        begin_phase(IDLE_NONE, 7'd127);
        send_access(FUNC_READ,  32'h0000_0030);
        send_access(FUNC_READ,  32'h0000_0038);

        run_phase(IDLE_NONE, 7'd64, 1'b0, 1'b0);
        run_phase(IDLE_SEND, 7'd127, 1'b0, 1'b0);
        run_phase(IDLE_RECV, 7'd1, 1'b1, 1'b1);
        run_phase(IDLE_BOTH, 7'd0, 1'b1, 1'b0);
        run_phase(IDLE_NONE, 7'd16, 1'b1, 1'b0);
        run_phase(IDLE_SEND, 7'($urandom_range(32, 1)), 1'b1, 1'b0);
        run_phase(IDLE_RECV, 7'd32, 1'b1, 1'b0);
        run_phase(IDLE_BOTH, 7'd5, 1'b1, 1'b1);

        // fill every free entry with pinned lines, then misses find no free entry
        begin_phase(IDLE_BOTH, 7'd127);
        repeat (60) send_access(FUNC_WRITE, $urandom);
        repeat (30) begin
            if ($urandom_range(1) == 0)
                send_access(1'($urandom_range(1)), $urandom);
            else
                send_mixed(1'b0);
        end

        pause_until_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
